// ===== rtl/core/tse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

  localparam int unsigned GRID_WIDTH  = 400;
  localparam int unsigned GRID_HEIGHT = 240;
  localparam int unsigned CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

  localparam int unsigned X_W   = $clog2(GRID_WIDTH);
  localparam int unsigned Y_W   = $clog2(GRID_HEIGHT);
  localparam int unsigned IDX_W = $clog2(CELL_COUNT);

  localparam int unsigned COLOUR_W     = 2;
  localparam int unsigned STATE_W      = 2;
  localparam int unsigned HEADING_W    = 3;
  localparam int unsigned SEL_W        = COLOUR_W + STATE_W;
  localparam int unsigned CELL_X_W     = 9;
  localparam int unsigned CELL_Y_W     = 8;

  localparam int unsigned LANE_W        = 3;
  localparam int unsigned CELLS_PER_ROW = 1 << LANE_W;
  localparam int unsigned ROW_W         = CELLS_PER_ROW * COLOUR_W;
  localparam int unsigned ROW_COUNT     = (CELL_COUNT + CELLS_PER_ROW - 1) / CELLS_PER_ROW;
  localparam int unsigned ROW_AW        = (IDX_W > LANE_W) ? (IDX_W - LANE_W) : 1;

  localparam logic [X_W-1:0] CENTRE_X = X_W'(GRID_WIDTH / 2);
  localparam logic [Y_W-1:0] CENTRE_Y = Y_W'(GRID_HEIGHT / 2);
  localparam logic [X_W-1:0] LAST_X   = X_W'(GRID_WIDTH - 1);
  localparam logic [Y_W-1:0] LAST_Y   = Y_W'(GRID_HEIGHT - 1);
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROW_COUNT - 1);

  localparam int unsigned COLOUR_RULE_W = 32;
  localparam int unsigned STATE_RULE_W  = 32;
  localparam int unsigned TURN_RULE_W   = 48;
  localparam int unsigned CFG_DATA_W    = 48;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_RULE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STATE_RULE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RULE   = 2'd2;

  localparam logic [HEADING_W-1:0] DIR_UP         = 3'd0;
  localparam logic [HEADING_W-1:0] DIR_UP_RIGHT   = 3'd1;
  localparam logic [HEADING_W-1:0] DIR_RIGHT      = 3'd2;
  localparam logic [HEADING_W-1:0] DIR_DOWN_RIGHT = 3'd3;
  localparam logic [HEADING_W-1:0] DIR_DOWN       = 3'd4;
  localparam logic [HEADING_W-1:0] DIR_DOWN_LEFT  = 3'd5;
  localparam logic [HEADING_W-1:0] DIR_LEFT       = 3'd6;
  localparam logic [HEADING_W-1:0] DIR_UP_LEFT    = 3'd7;

  typedef struct packed {
    logic accept;
    logic clr_start;
    logic clr_wr;
    logic rd_en;
    logic step_wr;
    logic restart_wr;
  } tse_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } tse_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/tse_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tse_in_if
  import tse_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                func;
  logic [STATE_W-1:0]  start_state;
  logic [COLOUR_W-1:0] start_colour;

  modport source (output valid, output func, output start_state, output start_colour,
                  input ready);
  modport sink (input valid, input func, input start_state, input start_colour,
                output ready);
endinterface

interface tse_out_if
  import tse_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CELL_X_W-1:0] cell_x;
  logic [CELL_Y_W-1:0] cell_y;
  logic [COLOUR_W-1:0] cell_colour;

  modport source (output valid, output cell_x, output cell_y, output cell_colour,
                  input ready);
  modport sink (input valid, input cell_x, input cell_y, input cell_colour,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tse_ctrl
  import tse_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_func_i,
  output logic          in_ready_o,
  input  wire tse_sts_t sts_i,
  output tse_cmd_t      cmd_o
);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_MODIFY  = 3'd3;
  localparam logic [2:0] ST_RESTART = 3'd4;

  logic [2:0] state_q, state_d;
  logic       restart_q, restart_d;

  always_comb begin
    state_d    = state_q;
    restart_d  = restart_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = restart_q ? ST_RESTART : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_func_i) begin
            cmd_o.clr_start = 1'b1;
            restart_d       = 1'b1;
            state_d         = ST_CLEAR;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (sts_i.out_free) begin
          cmd_o.step_wr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_RESTART: begin
        if (sts_i.out_free) begin
          cmd_o.restart_wr = 1'b1;
          restart_d        = 1'b0;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      restart_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      restart_q <= restart_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tse_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tse_dp
  import tse_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [STATE_W-1:0]    start_state_i,
  input  wire logic [COLOUR_W-1:0]   start_colour_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [CELL_X_W-1:0]        cell_x_o,
  output logic [CELL_Y_W-1:0]        cell_y_o,
  output logic [COLOUR_W-1:0]        cell_colour_o,
  input  wire tse_cmd_t              cmd_i,
  output tse_sts_t                   sts_o
);

  logic [COLOUR_RULE_W-1:0] colour_rule_q;
  logic [STATE_RULE_W-1:0]  state_rule_q;
  logic [TURN_RULE_W-1:0]   turn_rule_q;

  logic [X_W-1:0]       head_x_q, head_x_d;
  logic [Y_W-1:0]       head_y_q, head_y_d;
  logic [STATE_W-1:0]   ant_state_q;
  logic [HEADING_W-1:0] heading_q;
  logic [COLOUR_W-1:0]  start_colour_q;
  logic [IDX_W-1:0]     idx_q;
  logic [ROW_AW-1:0]    clr_cnt_q;

  logic [ROW_W-1:0]     mem_q [ROW_COUNT];
  logic [ROW_W-1:0]     rd_row_q;
  logic                 mem_we;
  logic [ROW_AW-1:0]    mem_waddr;
  logic [ROW_W-1:0]     mem_wdata;
  logic [ROW_AW-1:0]    row_addr;
  logic [LANE_W-1:0]    lane;

  logic [COLOUR_W-1:0]  cur_colour;
  logic [SEL_W-1:0]     sel;
  logic [SEL_W-1:0]     turn_sel;
  logic [COLOUR_W-1:0]  new_colour;
  logic [STATE_W-1:0]   new_state;
  logic [HEADING_W-1:0] turn;
  logic [HEADING_W-1:0] new_heading;
  logic [ROW_W-1:0]     step_row;
  logic [ROW_W-1:0]     restart_row;

  logic                 out_valid_q;
  logic [CELL_X_W-1:0]  cell_x_q;
  logic [CELL_Y_W-1:0]  cell_y_q;
  logic [COLOUR_W-1:0]  cell_colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colour_rule_q <= '0;
      state_rule_q  <= '0;
      turn_rule_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOUR_RULE: colour_rule_q <= cfg_data_i[COLOUR_RULE_W-1:0];
        CFG_STATE_RULE:  state_rule_q  <= cfg_data_i[STATE_RULE_W-1:0];
        CFG_TURN_RULE:   turn_rule_q   <= cfg_data_i[TURN_RULE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= IDX_W'(head_x_q) * IDX_W'(GRID_HEIGHT) + IDX_W'(head_y_q);
  end

  assign row_addr = ROW_AW'(idx_q >> LANE_W);
  assign lane     = idx_q[LANE_W-1:0];

  assign cur_colour  = rd_row_q[lane*COLOUR_W +: COLOUR_W];
  assign sel         = {cur_colour, ant_state_q};
  assign new_colour  = colour_rule_q[sel*COLOUR_W +: COLOUR_W];
  assign new_state   = state_rule_q[sel*STATE_W +: STATE_W];
  assign turn_sel    = {cur_colour, new_state};
  assign turn        = turn_rule_q[turn_sel*HEADING_W +: HEADING_W];
  assign new_heading = heading_q + turn;

  always_comb begin
    step_row = rd_row_q;
    step_row[lane*COLOUR_W +: COLOUR_W] = new_colour;
    restart_row = '0;
    restart_row[lane*COLOUR_W +: COLOUR_W] = start_colour_q;
  end

  always_comb begin
    head_y_d = head_y_q;
    case (new_heading) inside
      DIR_UP, DIR_UP_RIGHT, DIR_UP_LEFT: begin
        head_y_d = (head_y_q == '0) ? LAST_Y : head_y_q - 1'b1;
      end
      DIR_DOWN_RIGHT, DIR_DOWN, DIR_DOWN_LEFT: begin
        head_y_d = (head_y_q >= LAST_Y) ? '0 : head_y_q + 1'b1;
      end
      default: begin
      end
    endcase
    head_x_d = head_x_q;
    case (new_heading) inside
      DIR_UP_RIGHT, DIR_RIGHT, DIR_DOWN_RIGHT: begin
        head_x_d = (head_x_q >= LAST_X) ? '0 : head_x_q + 1'b1;
      end
      DIR_DOWN_LEFT, DIR_LEFT, DIR_UP_LEFT: begin
        head_x_d = (head_x_q == '0) ? LAST_X : head_x_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_x_q    <= CENTRE_X;
      head_y_q    <= CENTRE_Y;
      ant_state_q <= '0;
      heading_q   <= '0;
    end else if (cmd_i.clr_start) begin
      head_x_q    <= CENTRE_X;
      head_y_q    <= CENTRE_Y;
      ant_state_q <= start_state_i;
      heading_q   <= '0;
    end else if (cmd_i.step_wr) begin
      head_x_q    <= head_x_d;
      head_y_q    <= head_y_d;
      ant_state_q <= new_state;
      heading_q   <= new_heading;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      start_colour_q <= start_colour_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == LAST_ROW);

  always_comb begin
    mem_we    = cmd_i.clr_wr | cmd_i.step_wr | cmd_i.restart_wr;
    mem_waddr = cmd_i.clr_wr ? clr_cnt_q : row_addr;
    if (cmd_i.clr_wr) begin
      mem_wdata = '0;
    end else if (cmd_i.step_wr) begin
      mem_wdata = step_row;
    end else begin
      mem_wdata = restart_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_row_q <= mem_q[row_addr];
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step_wr || cmd_i.restart_wr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_wr || cmd_i.restart_wr) begin
      cell_x_q      <= CELL_X_W'(head_x_q);
      cell_y_q      <= CELL_Y_W'(head_y_q);
      cell_colour_q <= cmd_i.step_wr ? new_colour : start_colour_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_x_o      = cell_x_q;
  assign cell_y_o      = cell_y_q;
  assign cell_colour_o = cell_colour_q;

endmodule

`default_nettype wire

// ===== rtl/core/turmite_step_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Turmite step engine: a four-color, four-state turmite with eight headings
// that walks a toroidal grid of 2-bit cells held in an on-chip memory.
// Requests arrive on in_i: func 0 advances the head one step, func 1 clears
// the grid, centers the head with heading 0 and loads start_state and the
// center cell color. Each request yields exactly one response on out_o with
// the cell written and its new color. The user loads the rule tables through
// the cfg_we_i / cfg_idx_i / cfg_data_i write port only while the engine is
// idle; the engine itself does not enforce this. A step request is accepted
// in ST_IDLE, its grid row is read in ST_READ and written back in ST_MODIFY,
// which also loads the response register; no new step request is taken until
// that read-modify-write of one memory row is done.
// A restart request sweeps the memory one row of eight cells per cycle,
// all 12000 rows of the 400 by 240 grid, before its response appears.
// After reset the same sweep runs and in_i.ready stays low until it ends.
// The response sits in an output register; the next request is accepted
// while it waits, and a stalled receiver holds the engine in its write cycle.

module turmite_step_engine_unit
  import tse_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tse_in_if.sink                     in_i,
  tse_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  tse_cmd_t cmd;
  tse_sts_t sts;

  tse_ctrl u_tse_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tse_dp u_tse_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_state_i  (in_i.start_state),
    .start_colour_i (in_i.start_colour),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .cell_x_o       (out_o.cell_x),
    .cell_y_o       (out_o.cell_y),
    .cell_colour_o  (out_o.cell_colour),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tse_checker
  import tse_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [CELL_X_W-1:0] cell_x_i,
  input wire logic [CELL_Y_W-1:0] cell_y_i,
  input wire logic [COLOUR_W-1:0] cell_colour_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(cell_x_i) && $stable(cell_y_i) && $stable(cell_colour_i))
    else $error("response payload changed while stalled");

  a_out_on_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(cell_x_i) < GRID_WIDTH) && (32'(cell_y_i) < GRID_HEIGHT))
    else $error("response cell lies off the grid");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while previous one still in progress");

endmodule

bind turmite_step_engine_unit tse_checker u_tse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .cell_x_i      (out_o.cell_x),
  .cell_y_i      (out_o.cell_y),
  .cell_colour_i (out_o.cell_colour)
);

`default_nettype wire
